// File: rtl/deadline_timer_queue_unit_defines.svh
// Assertion macros used by the timer queue checker.
// Depends on nothing; included by files that hold assertions.
`ifndef DEADLINE_TIMER_QUEUE_UNIT_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define DTQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer queue check failed");

// Next-cycle implication, disabled in reset
`define DTQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer queue check failed");

`endif

// File: rtl/dtq_pkg.sv
// Types, codes and helpers for the deadline timer queue.
// No dependencies; imported by every module of the block.
package dtq_pkg;

   localparam int DL_W      = 48;
   localparam int IV_W      = 32;
   localparam int MAX_OUT   = 16;
   localparam int CNT_W     = 5;
   localparam int OUT_IDX_W = 4;
   localparam logic [DL_W-1:0] MAX_DL = {DL_W{1'b1}};

   localparam logic [1:0] MODE_ADD     = 2'd0;
   localparam logic [1:0] MODE_CANCEL  = 2'd1;
   localparam logic [1:0] MODE_REFRESH = 2'd2;
   localparam logic [1:0] MODE_TICK    = 2'd3;

   typedef enum logic [1:0] {
      SCAN_EARLY,
      SCAN_BEST,
      SCAN_APPLY,
      SCAN_WAIT
   } scan_kind_type;

   typedef enum logic [2:0] {
      PUSH_NONE,
      PUSH_ADD,
      PUSH_FULL,
      PUSH_TGT_OK,
      PUSH_TGT_BAD,
      PUSH_EXP,
      PUSH_EMPTY
   } push_type;

   typedef struct packed {
      logic [1:0]      mode;
      logic [IV_W-1:0] period_ms;
      logic            repeat_req;
      logic [3:0]      target_slot;
   } dtq_req_type;

   typedef struct packed {
      logic            status;
      logic [3:0]      slot_number;
      logic            expired;
      logic            new_earliest;
      logic [DL_W-1:0] wait_ms;
      logic            last;
   } dtq_rsp_type;

   // one buffered result, wait value is attached at output time
   typedef struct packed {
      logic       status;
      logic [3:0] slot;
      logic       expired;
      logic       early;
   } entry_type;

   typedef struct packed {
      logic          latch;
      logic          add_prep;
      logic          add_commit;
      logic          cancel_commit;
      logic          ref_commit;
      logic          tick_prep;
      logic          best_commit;
      logic          scan_start;
      scan_kind_type scan_kind;
      push_type      push;
      logic          wait_calc;
      logic          out_adv;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       full;
      logic       tgt_ok;
      logic       scan_done;
      logic       found;
      logic       buf_near_full;
      logic       buf_empty;
      logic       out_last;
   } sts_type;

   // now + interval, clamped to the largest deadline
   function automatic logic [DL_W-1:0] sat_add(input logic [DL_W-1:0] a,
                                               input logic [IV_W-1:0] b);
      logic [DL_W:0] s;
      s = {1'b0, a} + {{(DL_W + 1 - IV_W){1'b0}}, b};
      return s[DL_W] ? MAX_DL : s[DL_W-1:0];
   endfunction

endpackage

// File: rtl/dtq_controller.sv
// Sequencer of the timer queue: walks each transaction through its steps.
// Depends on dtq_pkg; drives dtq_datapath by command and status structs.
module dtq_controller
   import dtq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    req_stall,
   output logic    rsp_valid
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ADD_SCAN,
      ST_ADD_WAIT,
      ST_ADD_WR,
      ST_REF_WR,
      ST_TICK_SCAN,
      ST_TICK_WAIT,
      ST_TICK_DEC,
      ST_APPLY_SCAN,
      ST_APPLY_WAIT,
      ST_WAIT_SCAN,
      ST_WAIT_WAIT,
      ST_WAIT_CALC,
      ST_OUT
   } state_type;

   state_type state_ff;
   logic      req_stall_ff;
   logic      rsp_valid_ff;

   assign req_stall = req_stall_ff;
   assign rsp_valid = rsp_valid_ff;

   // command decode
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.latch = req_valid;
         end
         ST_DECODE: begin
            case (sts.mode)
               MODE_ADD: begin
                  if (sts.full) begin
                     cmd.push = PUSH_FULL;
                  end else begin
                     cmd.add_prep = 1'b1;
                  end
               end
               MODE_CANCEL: begin
                  if (sts.tgt_ok) begin
                     cmd.cancel_commit = 1'b1;
                     cmd.push          = PUSH_TGT_OK;
                  end else begin
                     cmd.push = PUSH_TGT_BAD;
                  end
               end
               MODE_REFRESH: begin
                  if (!sts.tgt_ok) begin
                     cmd.push = PUSH_TGT_BAD;
                  end
               end
               default: begin
                  cmd.tick_prep = 1'b1;
               end
            endcase
         end
         ST_ADD_SCAN: begin
            cmd.scan_start = 1'b1;
            cmd.scan_kind  = SCAN_EARLY;
         end
         ST_ADD_WR: begin
            cmd.add_commit = 1'b1;
            cmd.push       = PUSH_ADD;
         end
         ST_REF_WR: begin
            cmd.ref_commit = 1'b1;
            cmd.push       = PUSH_TGT_OK;
         end
         ST_TICK_SCAN: begin
            cmd.scan_start = 1'b1;
            cmd.scan_kind  = SCAN_BEST;
         end
         ST_TICK_DEC: begin
            if (sts.found) begin
               cmd.best_commit = 1'b1;
               cmd.push        = PUSH_EXP;
            end
         end
         ST_APPLY_SCAN: begin
            cmd.scan_start = 1'b1;
            cmd.scan_kind  = SCAN_APPLY;
         end
         ST_APPLY_WAIT: begin
            if (sts.scan_done && sts.buf_empty) begin
               cmd.push = PUSH_EMPTY;
            end
         end
         ST_WAIT_SCAN: begin
            cmd.scan_start = 1'b1;
            cmd.scan_kind  = SCAN_WAIT;
         end
         ST_WAIT_CALC: begin
            cmd.wait_calc = 1'b1;
         end
         ST_OUT: begin
            cmd.out_adv = !rsp_stall;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // state and handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_stall_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff     <= ST_DECODE;
                  req_stall_ff <= 1'b1;
               end
            end
            ST_DECODE: begin
               case (sts.mode)
                  MODE_ADD: begin
                     state_ff <= sts.full ? ST_WAIT_SCAN : ST_ADD_SCAN;
                  end
                  MODE_CANCEL: begin
                     state_ff <= ST_WAIT_SCAN;
                  end
                  MODE_REFRESH: begin
                     state_ff <= sts.tgt_ok ? ST_REF_WR : ST_WAIT_SCAN;
                  end
                  default: begin
                     state_ff <= ST_TICK_SCAN;
                  end
               endcase
            end
            ST_ADD_SCAN: begin
               state_ff <= ST_ADD_WAIT;
            end
            ST_ADD_WAIT: begin
               if (sts.scan_done) begin
                  state_ff <= ST_ADD_WR;
               end
            end
            ST_ADD_WR: begin
               state_ff <= ST_WAIT_SCAN;
            end
            ST_REF_WR: begin
               state_ff <= ST_WAIT_SCAN;
            end
            ST_TICK_SCAN: begin
               state_ff <= ST_TICK_WAIT;
            end
            ST_TICK_WAIT: begin
               if (sts.scan_done) begin
                  state_ff <= ST_TICK_DEC;
               end
            end
            ST_TICK_DEC: begin
               if (sts.found && !sts.buf_near_full) begin
                  state_ff <= ST_TICK_SCAN;
               end else begin
                  state_ff <= ST_APPLY_SCAN;
               end
            end
            ST_APPLY_SCAN: begin
               state_ff <= ST_APPLY_WAIT;
            end
            ST_APPLY_WAIT: begin
               if (sts.scan_done) begin
                  state_ff <= ST_WAIT_SCAN;
               end
            end
            ST_WAIT_SCAN: begin
               state_ff <= ST_WAIT_WAIT;
            end
            ST_WAIT_WAIT: begin
               if (sts.scan_done) begin
                  state_ff <= ST_WAIT_CALC;
               end
            end
            ST_WAIT_CALC: begin
               state_ff     <= ST_OUT;
               rsp_valid_ff <= 1'b1;
            end
            ST_OUT: begin
               if (!rsp_stall && sts.out_last) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b0;
                  req_stall_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// File: rtl/dtq_datapath.sv
// Datapath of the timer queue: slot memory, armed flags, scan engine,
// clock count and result buffer. Depends on dtq_pkg.
module dtq_datapath
   import dtq_pkg::*;
#(
   parameter int SLOTS = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  dtq_req_type req_data,
   input  cmd_type     cmd,
   output sts_type     sts,
   output dtq_rsp_type rsp_data
);

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   // latched transaction and time
   dtq_req_type     req_ff;
   logic [DL_W-1:0] now_ff;

   // slot state
   logic [SLOTS-1:0] armed_ff;
   logic [SLOTS-1:0] rep_ff;
   logic [DL_W-1:0]  dl_mem [SLOTS];
   logic [IV_W-1:0]  iv_mem [SLOTS];
   logic             pr_mem [SLOTS];
   logic [DL_W-1:0]  rd_dl_ff;
   logic [IV_W-1:0]  rd_iv_ff;
   logic             rd_pr_ff;

   // scan engine
   logic            busy_ff;
   logic [CW-1:0]   addr_ff;
   logic            dv_ff;
   logic [SW-1:0]   didx_ff;
   scan_kind_type   kind_ff;
   logic            early_ff;
   logic            found_ff;
   logic [DL_W-1:0] best_dl_ff;
   logic [SW-1:0]   best_idx_ff;

   // add bookkeeping and output
   logic [SW-1:0]   new_slot_ff;
   logic [DL_W-1:0] new_dl_ff;
   logic [DL_W-1:0] wait_ff;
   entry_type       buf_ff [MAX_OUT];
   logic [CNT_W-1:0] n_ff;
   logic [OUT_IDX_W-1:0] oidx_ff;

   logic [SW-1:0]   free_idx;
   logic            full;
   logic [SW-1:0]   tgt_idx;
   logic            tgt_ok;
   logic [SW-1:0]   rd_addr;
   logic            issue;
   logic            scan_done;
   logic            armed_e;
   logic            before_new;
   logic            due;
   logic            better;
   logic [DL_W-1:0] resched;
   logic            apply_hit;
   logic            wr_en;
   logic [SW-1:0]   wr_addr;
   logic [DL_W-1:0] wr_dl;
   entry_type       entry_in;

   // lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!armed_ff[i]) begin
            free_idx = SW'(i);
         end
      end
   end

   assign full    = &armed_ff;
   assign tgt_idx = SW'(req_ff.target_slot);
   assign tgt_ok  = (32'(req_ff.target_slot) < SLOTS) && armed_ff[tgt_idx];

   // scan element evaluation
   assign rd_addr    = busy_ff ? addr_ff[SW-1:0] : tgt_idx;
   assign issue      = busy_ff && (addr_ff < CW'(SLOTS));
   assign scan_done  = dv_ff && (didx_ff == SW'(SLOTS - 1));
   assign armed_e    = armed_ff[didx_ff];
   assign before_new = (new_dl_ff < rd_dl_ff) ||
                       ((new_dl_ff == rd_dl_ff) && (new_slot_ff > didx_ff));
   assign due        = armed_e && !rep_ff[didx_ff] && (rd_dl_ff <= now_ff);
   assign better     = !found_ff || (rd_dl_ff < best_dl_ff) ||
                       ((rd_dl_ff == best_dl_ff) && (didx_ff > best_idx_ff));
   assign resched    = sat_add(now_ff, rd_iv_ff);
   assign apply_hit  = dv_ff && (kind_ff == SCAN_APPLY) && rep_ff[didx_ff];

   // deadline write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = new_slot_ff;
      wr_dl   = new_dl_ff;
      if (cmd.add_commit) begin
         wr_en = 1'b1;
      end else if (cmd.ref_commit) begin
         wr_en   = 1'b1;
         wr_addr = tgt_idx;
         wr_dl   = resched;
      end else if (apply_hit && rd_pr_ff) begin
         wr_en   = 1'b1;
         wr_addr = didx_ff;
         wr_dl   = resched;
      end
   end

   // slot memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         dl_mem[wr_addr] <= wr_dl;
      end
      if (cmd.add_commit) begin
         iv_mem[new_slot_ff] <= req_ff.period_ms;
         pr_mem[new_slot_ff] <= req_ff.repeat_req;
      end
      rd_dl_ff <= dl_mem[rd_addr];
      rd_iv_ff <= iv_mem[rd_addr];
      rd_pr_ff <= pr_mem[rd_addr];
   end

   // armed flags, report mask and time
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= '0;
         rep_ff   <= '0;
         now_ff   <= '0;
      end else begin
         if (cmd.add_commit) begin
            armed_ff[new_slot_ff] <= 1'b1;
         end
         if (cmd.cancel_commit) begin
            armed_ff[tgt_idx] <= 1'b0;
         end
         if (apply_hit && !rd_pr_ff) begin
            armed_ff[didx_ff] <= 1'b0;
         end
         if (cmd.tick_prep) begin
            rep_ff <= '0;
            if (now_ff != MAX_DL) begin
               now_ff <= now_ff + 1'b1;
            end
         end
         if (cmd.best_commit) begin
            rep_ff[best_idx_ff] <= 1'b1;
         end
      end
   end

   // scan sequencing: one slot read per cycle, the read data registered before it is checked
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         dv_ff   <= 1'b0;
      end else begin
         dv_ff <= issue;
         if (cmd.scan_start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && !issue) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      didx_ff <= addr_ff[SW-1:0];
      if (cmd.scan_start) begin
         addr_ff  <= '0;
         kind_ff  <= cmd.scan_kind;
         found_ff <= 1'b0;
         early_ff <= 1'b1;
      end else begin
         if (issue) begin
            addr_ff <= addr_ff + 1'b1;
         end
         if (dv_ff) begin
            case (kind_ff)
               SCAN_EARLY: begin
                  if (armed_e && (didx_ff != new_slot_ff) && !before_new) begin
                     early_ff <= 1'b0;
                  end
               end
               SCAN_BEST: begin
                  if (due && better) begin
                     found_ff    <= 1'b1;
                     best_dl_ff  <= rd_dl_ff;
                     best_idx_ff <= didx_ff;
                  end
               end
               SCAN_WAIT: begin
                  if (armed_e && (!found_ff || (rd_dl_ff < best_dl_ff))) begin
                     found_ff   <= 1'b1;
                     best_dl_ff <= rd_dl_ff;
                  end
               end
               default: begin
                  found_ff <= found_ff;
               end
            endcase
         end
      end
   end

   // add preparation and wait computation
   always_ff @(posedge clock) begin
      if (cmd.add_prep) begin
         new_slot_ff <= free_idx;
         new_dl_ff   <= sat_add(now_ff, req_ff.period_ms);
      end
      if (cmd.wait_calc) begin
         if (!found_ff) begin
            wait_ff <= MAX_DL;
         end else if (best_dl_ff <= now_ff) begin
            wait_ff <= '0;
         end else begin
            wait_ff <= best_dl_ff - now_ff;
         end
      end
      if (cmd.latch) begin
         req_ff <= req_data;
      end
   end

   // result entry selection
   always_comb begin
      entry_in = '0;
      case (cmd.push)
         PUSH_FULL: begin
            entry_in.status = 1'b1;
         end
         PUSH_ADD: begin
            entry_in.slot  = 4'(new_slot_ff);
            entry_in.early = early_ff;
         end
         PUSH_TGT_OK: begin
            entry_in.slot = req_ff.target_slot;
         end
         PUSH_TGT_BAD: begin
            entry_in.status = 1'b1;
            entry_in.slot   = req_ff.target_slot;
         end
         PUSH_EXP: begin
            entry_in.slot    = 4'(best_idx_ff);
            entry_in.expired = 1'b1;
         end
         default: begin
            entry_in = '0;
         end
      endcase
   end

   // result buffer
   always_ff @(posedge clock) begin
      if (cmd.push != PUSH_NONE) begin
         buf_ff[n_ff[OUT_IDX_W-1:0]] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff    <= '0;
         oidx_ff <= '0;
      end else if (cmd.latch) begin
         n_ff    <= '0;
         oidx_ff <= '0;
      end else begin
         if (cmd.push != PUSH_NONE) begin
            n_ff <= n_ff + 1'b1;
         end
         if (cmd.out_adv) begin
            oidx_ff <= oidx_ff + 1'b1;
         end
      end
   end

   // result and status
   always_comb begin
      rsp_data.status       = buf_ff[oidx_ff].status;
      rsp_data.slot_number  = buf_ff[oidx_ff].slot;
      rsp_data.expired      = buf_ff[oidx_ff].expired;
      rsp_data.new_earliest = buf_ff[oidx_ff].early;
      rsp_data.wait_ms      = wait_ff;
      rsp_data.last         = ({1'b0, oidx_ff} == (n_ff - 1'b1));
   end

   always_comb begin
      sts.mode          = req_ff.mode;
      sts.full          = full;
      sts.tgt_ok        = tgt_ok;
      sts.scan_done     = scan_done;
      sts.found         = found_ff;
      sts.buf_near_full = (n_ff == CNT_W'(MAX_OUT - 1));
      sts.buf_empty     = (n_ff == '0);
      sts.out_last      = rsp_data.last;
   end

endmodule

// File: rtl/deadline_timer_queue_unit.sv
// Top level of the deadline timer queue.
// Depends on dtq_pkg, dtq_controller and dtq_datapath.
//
// Keeps SLOTS one-shot or periodic timers against a millisecond count and
// serves one transaction at a time: add, cancel, refresh or tick. Each slot
// pass reads the slot memory through its single read port, one slot per
// cycle. Cancel and refresh run one wait pass, add an early-check pass and
// a wait pass, and a tick that reports k timers k+1 search passes, each with
// its decision step, then an apply pass and a wait pass; one search pass
// fewer when all sixteen result places fill. Results then go out in order,
// held while rsp_stall is high. While a transaction is in work or its
// results wait, req_stall stays high. After reset no timer is armed and the
// count is zero; no clearing pass is needed.
module deadline_timer_queue_unit
   import dtq_pkg::*;
#(
   parameter int SLOTS = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  dtq_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output dtq_rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   // sequencer
   dtq_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid)
   );

   // storage and arithmetic
   dtq_datapath #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

// File: rtl/dtq_checker.sv
// Port-level checks for the deadline timer queue, bound to the top level.
// Depends on dtq_pkg and deadline_timer_queue_unit_defines.svh.
`include "deadline_timer_queue_unit_defines.svh"

module dtq_checker
   import dtq_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input dtq_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input dtq_rsp_type rsp_data
);

   // a stalled result holds
   `DTQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   // no new transaction while results are pending
   `DTQ_ASSERT_NOW(a_no_overlap, clock, reset, rsp_valid, req_stall)
   // nothing follows the final result of a transaction
   `DTQ_ASSERT_NEXT(a_last_ends, clock, reset, rsp_valid && !rsp_stall && rsp_data.last, !rsp_valid)
   // expiry reports are never refusals or add results
   `DTQ_ASSERT_NOW(a_exp_clean, clock, reset, rsp_valid && rsp_data.expired, rsp_data.status == 1'b0 && rsp_data.new_earliest == 1'b0)

endmodule

bind deadline_timer_queue_unit dtq_checker u_dtq_checker (.*);
